[sv/cckb_pkg.sv]
`default_nettype none

package cckb_pkg;

  // action codes
  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_PIXEL  = 1'b1;

  // register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 2'd2;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIM_REG_W  = 11;
  localparam int unsigned STRIDE_REG_W = 13;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned SPAN_W = 10;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned ADDR_W = 22;

  // clipped coordinates fit this width for the largest MAX_DIM (4096)
  localparam int unsigned COORD_W = 12;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // one visible, opaque pixel on its way to the address stage
  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [PIX_W-1:0]   data;
  } blit_req_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

`default_nettype wire

[sv/cckb_front.sv]
`default_nettype none

module cckb_front #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               action,
  input  wire logic signed [cckb_pkg::POS_W-1:0]  pos_x,
  input  wire logic signed [cckb_pkg::POS_W-1:0]  pos_y,
  input  wire logic [cckb_pkg::SPAN_W-1:0]        sprite_width,
  input  wire logic [cckb_pkg::SPAN_W-1:0]        sprite_height,
  input  wire logic [cckb_pkg::PIX_W-1:0]         pixel_value,
  input  wire logic [cckb_pkg::DIM_REG_W-1:0]     fb_width,
  input  wire logic [cckb_pkg::DIM_REG_W-1:0]     fb_height,
  input  wire cckb_pkg::q_status_t                q_stat,
  output logic                                    push,
  output cckb_pkg::blit_req_t                     push_req
);

  logic signed [cckb_pkg::POS_W-1:0] origin_x, origin_y;
  logic [cckb_pkg::SPAN_W-1:0] span_w, span_h, src_col, src_row;
  logic [cckb_pkg::SPAN_W-1:0] src_col_next, src_row_next;

  logic                       accept;
  logic                       active;
  logic signed [cckb_pkg::POS_W:0] dx, dy;
  logic                       x_in, y_in, emit;
  logic [cckb_pkg::SPAN_W:0]  col_inc;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign active = (span_w != '0) && (span_h != '0) && (src_row < span_h);

  assign dx = $signed({origin_x[cckb_pkg::POS_W-1], origin_x})
            + $signed({1'b0, {(cckb_pkg::POS_W - cckb_pkg::SPAN_W){1'b0}}, src_col});
  assign dy = $signed({origin_y[cckb_pkg::POS_W-1], origin_y})
            + $signed({1'b0, {(cckb_pkg::POS_W - cckb_pkg::SPAN_W){1'b0}}, src_row});

  // clip: register limit and the MAX_DIM cap both apply
  assign x_in = !dx[cckb_pkg::POS_W]
             && (dx[cckb_pkg::POS_W-1:0] <
                 {{(cckb_pkg::POS_W - cckb_pkg::DIM_REG_W){1'b0}}, fb_width})
             && (dx[cckb_pkg::POS_W-1:0] < cckb_pkg::POS_W'(MAX_DIM));
  assign y_in = !dy[cckb_pkg::POS_W]
             && (dy[cckb_pkg::POS_W-1:0] <
                 {{(cckb_pkg::POS_W - cckb_pkg::DIM_REG_W){1'b0}}, fb_height})
             && (dy[cckb_pkg::POS_W-1:0] < cckb_pkg::POS_W'(MAX_DIM));
  assign emit = x_in && y_in && (pixel_value != '0);

  // raster walk
  always_comb begin
    col_inc = {1'b0, src_col} + 1'b1;
    if (col_inc >= {1'b0, span_w}) begin
      src_col_next = '0;
      src_row_next = src_row + 1'b1;
    end else begin
      src_col_next = col_inc[cckb_pkg::SPAN_W-1:0];
      src_row_next = src_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      span_w   <= '0;
      span_h   <= '0;
      src_col  <= '0;
      src_row  <= '0;
    end else if (accept) begin
      if (action == cckb_pkg::ACT_HEADER) begin
        origin_x <= pos_x;
        origin_y <= pos_y;
        span_w   <= sprite_width;
        span_h   <= sprite_height;
        src_col  <= '0;
        src_row  <= '0;
      end else if (active) begin
        src_col <= src_col_next;
        src_row <= src_row_next;
      end
    end
  end

  assign push = accept && (action == cckb_pkg::ACT_PIXEL) && active && emit;

  always_comb begin
    push_req.dx   = dx[cckb_pkg::COORD_W-1:0];
    push_req.dy   = dy[cckb_pkg::COORD_W-1:0];
    push_req.data = pixel_value;
  end

endmodule

`default_nettype wire

[sv/cckb_queue.sv]
`default_nettype none

module cckb_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire cckb_pkg::blit_req_t  push_req,
  input  wire logic                 pop,
  output cckb_pkg::blit_req_t       pop_req,
  output cckb_pkg::q_status_t       q_stat
);

  cckb_pkg::blit_req_t entries [cckb_pkg::Q_DEPTH];

  logic [cckb_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cckb_pkg::Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_req         = entries[rd_ptr];
  assign q_stat.full     = (count == cckb_pkg::Q_CNT_W'(cckb_pkg::Q_DEPTH));
  assign q_stat.nonempty = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.nonempty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cckb_pkg::Q_CNT_W'(cckb_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0) || (count == cckb_pkg::Q_CNT_W'(cckb_pkg::Q_DEPTH))
      |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[sv/cckb_back.sv]
`default_nettype none

module cckb_back #(
  parameter int unsigned STRIDE_W = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cckb_pkg::q_status_t           q_stat,
  input  wire cckb_pkg::blit_req_t           pop_req,
  output logic                               pop,
  input  wire logic [STRIDE_W-1:0]           stride,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cckb_pkg::ADDR_W-1:0]        write_addr,
  output logic [cckb_pkg::PIX_W-1:0]         write_data
);

  localparam int unsigned PROD_W = cckb_pkg::COORD_W + STRIDE_W;
  localparam int unsigned WIDE_W = cckb_pkg::ADDR_W + PROD_W + 1;

  // stage 1: row offset
  logic                          s1_valid;
  logic [PROD_W-1:0]             s1_prod;
  logic [cckb_pkg::COORD_W-1:0]  s1_dx;
  logic [cckb_pkg::PIX_W-1:0]    s1_data;

  logic                          out_en, s1_en;
  logic [WIDE_W-1:0]             addr_wide;

  assign out_en = !out_valid || out_ready;
  assign s1_en  = !s1_valid || out_en;
  assign pop    = q_stat.nonempty && s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && pop) begin
      s1_prod <= PROD_W'(pop_req.dy) * PROD_W'(stride);
      s1_dx   <= pop_req.dx;
      s1_data <= pop_req.data;
    end
  end

  assign addr_wide = {{(cckb_pkg::ADDR_W + 1){1'b0}}, s1_prod}
                   + {{(WIDE_W - cckb_pkg::COORD_W){1'b0}}, s1_dx};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      write_addr <= addr_wide[cckb_pkg::ADDR_W-1:0];
      write_data <= s1_data;
    end
  end

endmodule

`default_nettype wire

[sv/clipped_color_key_blit.sv]
// Channel  | Direction | Handshake            | Beat payload
// ---------+-----------+----------------------+-------------------------------------------
// in       | sink      | in_valid / in_ready  | action, pos_x, pos_y, sprite_width,
//          |           |                      | sprite_height, pixel_value
// out      | source    | out_valid / out_ready| write_addr, write_data
// cfg      | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data (0 width, 1 height,
//          |           |                      | 2 stride; other indexes ignored)
//
// One input beat per clock, sustained while the queue is not full. A write beat
// leaves through the queue, the multiply stage and the output register, in order.
// Reset (rst, synchronous) empties the queue and the pipe, clears placement and
// walk state, and loads width 480, height 272, stride 480.
// in_ready drops only when the four-entry queue is full, so a stalled output
// backs up through the multiply stage and the queue before the input stalls.
// cfg_ready is always high; write config only with the block idle.
`default_nettype none

module clipped_color_key_blit #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned MAX_STRIDE = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // pixel / header beats
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   action,
  input  wire logic signed [cckb_pkg::POS_W-1:0]      pos_x,
  input  wire logic signed [cckb_pkg::POS_W-1:0]      pos_y,
  input  wire logic [cckb_pkg::SPAN_W-1:0]            sprite_width,
  input  wire logic [cckb_pkg::SPAN_W-1:0]            sprite_height,
  input  wire logic [cckb_pkg::PIX_W-1:0]             pixel_value,
  // framebuffer writes
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [cckb_pkg::ADDR_W-1:0]                 write_addr,
  output logic [cckb_pkg::PIX_W-1:0]                  write_data,
  // register writes
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [cckb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [cckb_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int unsigned STRIDE_W  = $clog2(MAX_STRIDE + 1);
  localparam int unsigned STR_CMP_W = 14;

  logic [cckb_pkg::DIM_REG_W-1:0]    fb_width;
  logic [cckb_pkg::DIM_REG_W-1:0]    fb_height;
  logic [cckb_pkg::STRIDE_REG_W-1:0] line_stride;

  logic [STR_CMP_W-1:0] stride_ext, stride_cap;
  logic [STRIDE_W-1:0]  stride;

  cckb_pkg::q_status_t q_stat;
  cckb_pkg::blit_req_t push_req, pop_req;
  logic                push, pop;

  // --- registers -----------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width    <= cckb_pkg::DIM_REG_W'(480);
      fb_height   <= cckb_pkg::DIM_REG_W'(272);
      line_stride <= cckb_pkg::STRIDE_REG_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cckb_pkg::CFG_FB_WIDTH:    fb_width    <= cfg_data[cckb_pkg::DIM_REG_W-1:0];
        cckb_pkg::CFG_FB_HEIGHT:   fb_height   <= cfg_data[cckb_pkg::DIM_REG_W-1:0];
        cckb_pkg::CFG_LINE_STRIDE: line_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  // stride above MAX_STRIDE behaves as MAX_STRIDE
  assign stride_ext = {1'b0, line_stride};
  assign stride_cap = (stride_ext > STR_CMP_W'(MAX_STRIDE)) ? STR_CMP_W'(MAX_STRIDE)
                                                           : stride_ext;
  assign stride     = stride_cap[STRIDE_W-1:0];

  // --- front: header latch, raster walk, clip and key test ----------------
  cckb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .pixel_value   (pixel_value),
    .fb_width      (fb_width),
    .fb_height     (fb_height),
    .q_stat        (q_stat),
    .push          (push),
    .push_req      (push_req)
  );

  // --- queue: only pixels that will be written travel on ------------------
  cckb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .q_stat   (q_stat)
  );

  // --- back: y * stride, then + x into the output register ----------------
  cckb_back #(
    .STRIDE_W (STRIDE_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .pop_req    (pop_req),
    .pop        (pop),
    .stride     (stride),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .write_addr (write_addr),
    .write_data (write_data)
  );

endmodule

`default_nettype wire

[tb/tb_clipped_color_key_blit.sv]
`timescale 1ns / 1ps

// Clipping limits of the block as built (default parameters).
localparam int FB_DIM_CAP    = 1024;
localparam int FB_STRIDE_CAP = 4096;

typedef struct packed {
  logic [cckb_pkg::ADDR_W-1:0] addr;
  logic [cckb_pkg::PIX_W-1:0]  data;
} fb_write_t;

class fb_write_board;
  logic [cckb_pkg::DIM_REG_W-1:0]    fb_w;
  logic [cckb_pkg::DIM_REG_W-1:0]    fb_h;
  logic [cckb_pkg::STRIDE_REG_W-1:0] stride;
  logic signed [cckb_pkg::POS_W-1:0] org_x;
  logic signed [cckb_pkg::POS_W-1:0] org_y;
  logic [cckb_pkg::SPAN_W-1:0]       span_w;
  logic [cckb_pkg::SPAN_W-1:0]       span_h;
  logic [cckb_pkg::SPAN_W-1:0]       col;
  logic [cckb_pkg::SPAN_W:0]         row;
  fb_write_t                         pending_writes[$];
  int                                failures;

  function new();
    fb_w     = 11'd480;
    fb_h     = 11'd272;
    stride   = 13'd480;
    org_x    = '0;
    org_y    = '0;
    span_w   = '0;
    span_h   = '0;
    col      = '0;
    row      = '0;
    failures = 0;
  endfunction

  function int vis_w();
    return (int'(fb_w) > FB_DIM_CAP) ? FB_DIM_CAP : int'(fb_w);
  endfunction

  function int vis_h();
    return (int'(fb_h) > FB_DIM_CAP) ? FB_DIM_CAP : int'(fb_h);
  endfunction

  function void set_reg(logic [cckb_pkg::CFG_IDX_W-1:0] idx,
                        logic [cckb_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      cckb_pkg::CFG_FB_WIDTH:    fb_w = val[cckb_pkg::DIM_REG_W-1:0];
      cckb_pkg::CFG_FB_HEIGHT:   fb_h = val[cckb_pkg::DIM_REG_W-1:0];
      cckb_pkg::CFG_LINE_STRIDE: stride = val;
      default: ;
    endcase
  endfunction

  // Walks the sprite and queues the framebuffer write an accepted beat causes.
  function void predict_write(logic act,
                              logic signed [cckb_pkg::POS_W-1:0] px,
                              logic signed [cckb_pkg::POS_W-1:0] py,
                              logic [cckb_pkg::SPAN_W-1:0] sw,
                              logic [cckb_pkg::SPAN_W-1:0] sh,
                              logic [cckb_pkg::PIX_W-1:0] pix);
    int          dx;
    int          dy;
    int          st;
    logic [31:0] lin;
    fb_write_t   wr;
    if (act == cckb_pkg::ACT_HEADER) begin
      org_x  = px;
      org_y  = py;
      span_w = sw;
      span_h = sh;
      col    = '0;
      row    = '0;
      return;
    end
    if (span_w == 0 || span_h == 0 || int'(row) >= int'(span_h)) return;
    dx = int'(org_x) + int'(col);
    dy = int'(org_y) + int'(row);
    st = (int'(stride) > FB_STRIDE_CAP) ? FB_STRIDE_CAP : int'(stride);
    if (int'(col) + 1 >= int'(span_w)) begin
      col = '0;
      row = row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    if (dx < 0 || dy < 0 || dx >= vis_w() || dy >= vis_h() || pix == 0) return;
    lin = 32'(dy * st + dx);
    wr.addr = lin[cckb_pkg::ADDR_W-1:0];
    wr.data = pix;
    pending_writes.push_back(wr);
  endfunction

  function void check_write(logic [cckb_pkg::ADDR_W-1:0] addr,
                            logic [cckb_pkg::PIX_W-1:0] data);
    fb_write_t exp_wr;
    if (pending_writes.size() == 0) begin
      $error("write beat with none expected: addr %0h data %0h", addr, data);
      failures++;
      return;
    end
    exp_wr = pending_writes.pop_front();
    if (addr !== exp_wr.addr) begin
      $error("write_addr: expected %0h, got %0h", exp_wr.addr, addr);
      failures++;
    end
    if (data !== exp_wr.data) begin
      $error("write_data: expected %0h, got %0h", exp_wr.data, data);
      failures++;
    end
  endfunction

  function int pending();
    return pending_writes.size();
  endfunction
endclass

module tb_clipped_color_key_blit;

  localparam int CYCLE_LIMIT = 200000;
  // cfg_index 3 is not a register; writes to it must change nothing
  localparam logic [cckb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // pipe depth after the last write: queue, multiply, output register, plus margin
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               action = cckb_pkg::ACT_HEADER;
  logic signed [cckb_pkg::POS_W-1:0]  pos_x = '0;
  logic signed [cckb_pkg::POS_W-1:0]  pos_y = '0;
  logic [cckb_pkg::SPAN_W-1:0]        sprite_width = '0;
  logic [cckb_pkg::SPAN_W-1:0]        sprite_height = '0;
  logic [cckb_pkg::PIX_W-1:0]         pixel_value = '0;

  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [cckb_pkg::ADDR_W-1:0]        write_addr;
  logic [cckb_pkg::PIX_W-1:0]         write_data;

  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [cckb_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [cckb_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  // idling switches, flipped per sprite by the stimulus
  bit in_gaps    = 1'b0;
  bit out_stalls = 1'b0;
  int stall_left = 0;
  int cycles     = 0;

  fb_write_board sb = new();

  clipped_color_key_blit DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .pixel_value   (pixel_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_addr    (write_addr),
    .write_data    (write_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_clipped_color_key_blit failed");
      $finish;
    end
  end

  // Write sink: ready held high, with stall bursts when enabled.
  // Only one assignment to out_ready per falling edge.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_stalls && $urandom_range(0, 5) == 0)
        stall_left <= $urandom_range(1, 6);
    end
  end

  // Outputs are taken at the rising edge, before the block's registers move.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_write(write_addr, write_data);
  end

  // One input beat. Entered on a falling edge; returns on a falling edge with
  // valid still high unless in_gaps idled it, so a following beat keeps valid
  // up without a dip. Anything else that lets time pass must drop valid first.
  task automatic put_beat(input logic act,
                          input logic signed [cckb_pkg::POS_W-1:0] px,
                          input logic signed [cckb_pkg::POS_W-1:0] py,
                          input logic [cckb_pkg::SPAN_W-1:0] sw,
                          input logic [cckb_pkg::SPAN_W-1:0] sh,
                          input logic [cckb_pkg::PIX_W-1:0] pix);
    in_valid      <= 1'b1;
    action        <= act;
    pos_x         <= px;
    pos_y         <= py;
    sprite_width  <= sw;
    sprite_height <= sh;
    pixel_value   <= pix;
    do @(posedge clk); while (!in_ready);
    sb.predict_write(act, px, py, sw, sh, pix);
    @(negedge clk);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Headers carry a junk pixel and pixels carry junk header fields: both ignored.
  task automatic put_header(input logic signed [cckb_pkg::POS_W-1:0] px,
                            input logic signed [cckb_pkg::POS_W-1:0] py,
                            input logic [cckb_pkg::SPAN_W-1:0] sw,
                            input logic [cckb_pkg::SPAN_W-1:0] sh);
    put_beat(cckb_pkg::ACT_HEADER, px, py, sw, sh, 16'($urandom));
  endtask

  task automatic put_pixel(input logic [cckb_pkg::PIX_W-1:0] pix);
    put_beat(cckb_pkg::ACT_PIXEL, 16'($urandom), 16'($urandom),
             10'($urandom), 10'($urandom), pix);
  endtask

  function automatic logic [cckb_pkg::PIX_W-1:0] any_pixel();
    if ($urandom_range(0, 3) == 0) return '0;
    return 16'($urandom);
  endfunction

  // Drop valid, wait for every predicted write, then idle DRAIN_CYCLES so that
  // any write still in the pipe reaches the checker.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(input logic [cckb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cckb_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_fb(input int w, input int h, input int s);
    write_reg(cckb_pkg::CFG_FB_WIDTH, 13'(w));
    write_reg(cckb_pkg::CFG_FB_HEIGHT, 13'(h));
    write_reg(cckb_pkg::CFG_LINE_STRIDE, 13'(s));
  endtask

  // Sprite straddling the right and bottom edges of a 1024-line framebuffer.
  task automatic corner_sweep();
    put_header(16'sd1000, 16'sd1023, 10'd30, 10'd2);
    repeat (60) put_pixel(16'($urandom_range(1, 65535)));
  endtask

  // Mostly whole sprites placed around the visible area with random content;
  // some overrun or get cut short by the next header, and some headers are
  // plain noise across the whole field range.
  task automatic random_sprites(input int target, input bit calm);
    int sent;
    int n;
    int w;
    int h;
    sent = 0;
    while (sent < target) begin
      in_gaps    = !calm && ($urandom_range(0, 3) != 0);
      out_stalls = !calm && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        put_header(16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
        repeat ($urandom_range(0, 4)) put_pixel(any_pixel());
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        put_header(16'(int'($urandom_range(0, sb.vis_w() + 2 * w)) - w),
                   16'(int'($urandom_range(0, sb.vis_h() + 2 * h)) - h),
                   10'(w), 10'(h));
        n = w * h;
        case ($urandom_range(0, 9))
          0: n = n + $urandom_range(1, 3);     // excess pixels, dropped
          1: n = $urandom_range(0, n - 1);     // cut short by the next header
          default: ;
        endcase
        repeat (n) put_pixel(any_pixel());
        sent = sent + n + 1;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, reset registers (480 x 272, stride 480) ---
    put_pixel(16'hABCD);                       // no header yet: dropped
    put_header(16'sd0, 16'sd0, 10'd2, 10'd2);
    put_pixel(16'hFFFF);
    put_pixel(16'h0000);                       // transparent key
    put_pixel(16'h0001);
    put_pixel(16'h8000);
    put_pixel(16'h1234);                       // beyond w*h: dropped
    put_header(-16'sd1, -16'sd1, 10'd2, 10'd2); // only bottom-right lands
    repeat (4) put_pixel(16'h5A5A);
    put_header(16'sd479, 16'sd271, 10'd2, 10'd2); // last visible pixel only
    repeat (4) put_pixel(16'hA5A5);
    put_header(16'sd5, 16'sd5, 10'd0, 10'd4);  // zero width
    put_pixel(16'h7777);
    put_header(16'sd5, 16'sd5, 10'd4, 10'd0);  // zero height
    put_pixel(16'h7777);
    put_header(16'sd32767, -16'sd32768, 10'd1023, 10'd1023);
    put_pixel(16'hFFFF);
    put_header(-16'sd32768, 16'sd32767, 10'd1023, 10'd1023);
    put_pixel(16'hFFFF);
    settle();
    random_sprites(60, 1'b0);
    settle();

    // --- largest plain setting ---
    set_fb(1024, 1024, 4096);
    corner_sweep();
    random_sprites(60, 1'b0);
    settle();

    // --- all-ones registers: act as the caps ---
    set_fb(2047, 2047, 8191);
    corner_sweep();
    random_sprites(60, 1'b0);
    settle();

    // --- empty framebuffer: nothing visible; stray index must be ignored ---
    set_fb(0, 0, 0);
    write_reg(CFG_UNUSED, 13'h1FFF);
    random_sprites(40, 1'b0);
    settle();

    // --- tiny framebuffer, clipping on most sprites ---
    set_fb(16, 8, 16);
    random_sprites(60, 1'b0);
    settle();

    // --- random registers, no idling on either side ---
    set_fb($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 8191));
    random_sprites(60, 1'b1);
    settle();

    if (sb.failures == 0)
      $display("tb_clipped_color_key_blit passed");
    else
      $display("tb_clipped_color_key_blit failed");
    $finish;
  end

endmodule
